>>> hw/rtl/gaussian_polar_generator_assert.svh
// Assertion macros used by the Gaussian polar generator checker.
// Needs i_clk and i_rst_n visible where a macro is used.
`ifndef GAUSSIAN_POLAR_GENERATOR_ASSERT_SVH
`define GAUSSIAN_POLAR_GENERATOR_ASSERT_SVH

// Next-cycle implication, off while reset is low.
`define GPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define GPG_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/gpg_pkg.sv
// Shared types and constants of the Gaussian polar generator.
// No dependencies.
`timescale 1ns / 1ps

package gpg_pkg;

    localparam int WORD_W     = 32;
    localparam int WIDE_W     = 64;
    localparam int SQRT_STEPS = 32;   // two radicand bits per step
    localparam int DIV_STEPS  = 31;   // one quotient bit per step
    localparam int LOG_STEPS  = 32;   // one log2 fraction bit per squaring

    // round(2 ln2 * 2^30)
    localparam logic [WORD_W-1:0] LN2X2_Q30 = 32'd1488522236;

    // configuration register indexes
    localparam logic CFG_MEAN = 1'b0;
    localparam logic CFG_STD  = 1'b1;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] root;
    } t_sqrt_stat;

    typedef struct packed {
        logic                done;
        logic [DIV_STEPS-1:0] quot;
    } t_div_stat;

endpackage

>>> hw/rtl/gaussian_polar_generator.sv
// Top level of the Marsaglia polar Gaussian generator: sequencer, shared multiplier,
// output register. Depends on gpg_pkg, gpg_sqrt, gpg_div.
//
//  channel  | direction | handshake                     | payload
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | uniform_a [31:0], uniform_b [63:32]
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | sample_value [31:0]
//  cfg      | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// A cached (second) sample runs ST_SCLM, ST_SCLQ, ST_SCLS, ST_EMIT into the output register.
// A new pair squares both words, shifts out the leading zeros of S (2..63), runs the
// log2 squaring loop on the multiplier, two passes on the square-root unit and two on the divider.
// A rejected pair frees the input from ST_CHK. Synchronous active-low reset clears
// phase, cache and output valid. A stalled output holds the finished sample while the
// sequencer waits; the next item is taken once the sample has moved into the output register.
`timescale 1ns / 1ps

module gaussian_polar_generator #(
    parameter int UNIFORM_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] uniform_a, [63:32] uniform_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sample_value
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam logic [31:0] HALF     = 32'(64'd1 << (UNIFORM_BITS - 1));
    localparam logic [6:0]  LOG_BASE = 7'(2 * UNIFORM_BITS - 2);

    // sequencer states
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SQA   = 5'd1;
    localparam logic [4:0] ST_SQB   = 5'd2;
    localparam logic [4:0] ST_SUM   = 5'd3;
    localparam logic [4:0] ST_CHK   = 5'd4;
    localparam logic [4:0] ST_NORM  = 5'd5;
    localparam logic [4:0] ST_LOGM  = 5'd6;
    localparam logic [4:0] ST_LOGS  = 5'd7;
    localparam logic [4:0] ST_TLN   = 5'd8;
    localparam logic [4:0] ST_LNM   = 5'd9;
    localparam logic [4:0] ST_SQW   = 5'd10;
    localparam logic [4:0] ST_WAITW = 5'd11;
    localparam logic [4:0] ST_SQR   = 5'd12;
    localparam logic [4:0] ST_WAITR = 5'd13;
    localparam logic [4:0] ST_SHF   = 5'd14;
    localparam logic [4:0] ST_DIV   = 5'd15;
    localparam logic [4:0] ST_WAITD = 5'd16;
    localparam logic [4:0] ST_GMUL  = 5'd17;
    localparam logic [4:0] ST_GSGN  = 5'd18;
    localparam logic [4:0] ST_SCLM  = 5'd19;
    localparam logic [4:0] ST_SCLQ  = 5'd20;
    localparam logic [4:0] ST_SCLS  = 5'd21;
    localparam logic [4:0] ST_EMIT  = 5'd22;

    logic [4:0]  r_state;
    logic        r_phase;
    logic [31:0] r_cache;
    logic signed [31:0] r_mean;
    logic [31:0] r_std;
    logic        r_ovalid;
    logic [31:0] r_odata;

    logic        r_neg_a;
    logic        r_neg_b;
    logic [31:0] r_mag_a;
    logic [31:0] r_mag_b;
    logic [63:0] r_prod;
    logic [63:0] r_s;
    logic [63:0] r_norm;
    logic [5:0]  r_e;
    logic [31:0] r_x;
    logic [31:0] r_frac;
    logic [4:0]  r_cnt;
    logic [31:0] r_t;
    logic [31:0] r_w;
    logic [31:0] r_root;
    logic        r_sel;
    logic [31:0] r_num;
    logic [30:0] r_c;
    logic [31:0] r_dev;
    logic signed [36:0] r_q;
    logic [31:0] r_res;

    logic [UNIFORM_BITS-1:0] n_ua;
    logic [UNIFORM_BITS-1:0] n_ub;
    logic [31:0] n_mag_a;
    logic [31:0] n_mag_b;
    logic signed [32:0] n_ma;
    logic signed [32:0] n_mb;
    logic signed [65:0] n_mul;
    logic        n_reject;
    logic [6:0]  n_exp;
    logic [38:0] n_t;
    logic [4:0]  n_k;
    logic [31:0] n_mag_sel;
    logic [63:0] n_g_sum;
    logic [31:0] n_g;
    logic [31:0] n_dev;
    logic signed [63:0] n_p;
    logic signed [37:0] n_r;
    logic        n_load;
    logic        n_sqrt_start;
    logic [63:0] n_radicand;
    logic        n_div_start;

    gpg_pkg::t_sqrt_stat w_sqrt;
    gpg_pkg::t_div_stat  w_div;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // offset words: a = u - 2^(B-1), kept as sign and magnitude
    always_comb begin
        n_ua    = s_axis_tdata[UNIFORM_BITS-1:0];
        n_ub    = s_axis_tdata[32 +: UNIFORM_BITS];
        n_mag_a = n_ua[UNIFORM_BITS-1] ? 32'(n_ua[UNIFORM_BITS-2:0])
                                       : HALF - 32'(n_ua[UNIFORM_BITS-2:0]);
        n_mag_b = n_ub[UNIFORM_BITS-1] ? 32'(n_ub[UNIFORM_BITS-2:0])
                                       : HALF - 32'(n_ub[UNIFORM_BITS-2:0]);
    end

    // shared multiplier operands
    always_comb begin
        n_ma = '0;
        n_mb = '0;
        unique case (r_state)
            ST_SQA: begin
                n_ma = {1'b0, r_mag_a};
                n_mb = {1'b0, r_mag_a};
            end
            ST_SQB: begin
                n_ma = {1'b0, r_mag_b};
                n_mb = {1'b0, r_mag_b};
            end
            ST_LOGM: begin
                n_ma = {1'b0, r_x};
                n_mb = {1'b0, r_x};
            end
            ST_LNM: begin
                n_ma = {1'b0, r_t};
                n_mb = {1'b0, gpg_pkg::LN2X2_Q30};
            end
            ST_GMUL: begin
                n_ma = {2'b00, r_c};
                n_mb = {1'b0, r_w};
            end
            ST_SCLM: begin
                n_ma = {1'b0, r_std};
                n_mb = {r_dev[31], r_dev};
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
        n_mul = n_ma * n_mb;
    end

    // datapath helpers
    always_comb begin
        n_reject   = (r_s == '0) || ((r_s >> (2 * UNIFORM_BITS - 2)) != '0);
        n_exp      = LOG_BASE - {1'b0, r_e};
        n_t        = {n_exp, 32'd0} - {7'd0, r_frac};
        n_k        = 5'((6'd63 - r_e) >> 1);
        n_mag_sel  = r_sel ? r_mag_b : r_mag_a;
        n_g_sum    = r_prod + 64'h0000_0000_4000_0000;
        n_g        = n_g_sum[62:31];
        n_dev      = (r_sel ? r_neg_b : r_neg_a) ? (32'd0 - n_g) : n_g;
        n_p        = $signed(r_prod) + 64'sd67108864;
        n_r        = 38'(r_q) + 38'(r_mean);
        n_load     = (r_state == ST_EMIT) && (!r_ovalid || m_axis_tready);
        n_sqrt_start = (r_state == ST_SQW) || (r_state == ST_SQR);
        n_radicand = (r_state == ST_SQW) ? {r_prod[63:24], 24'd0}
                   : (r_e[0] ? r_norm : {1'b0, r_norm[63:1]});
        n_div_start = (r_state == ST_DIV);
    end

    gpg_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_sqrt_start),
        .i_radicand (n_radicand),
        .o_stat     (w_sqrt)
    );

    gpg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_num   (r_num),
        .i_den   (r_root),
        .o_stat  (w_div)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= '0;
            r_std  <= 32'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gpg_pkg::CFG_MEAN: r_mean <= $signed(i_cfg_data);
                gpg_pkg::CFG_STD:  r_std  <= i_cfg_data;
                default:           r_std  <= r_std;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (n_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_odata <= r_res;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= 1'b0;
            r_cache <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= r_phase ? ST_SCLM : ST_SQA;
                    end
                end
                ST_SQA:   r_state <= ST_SQB;
                ST_SQB:   r_state <= ST_SUM;
                ST_SUM:   r_state <= ST_CHK;
                ST_CHK:   r_state <= n_reject ? ST_IDLE : ST_NORM;
                ST_NORM: begin
                    if (r_norm[63]) begin
                        r_state <= ST_LOGM;
                    end
                end
                ST_LOGM:  r_state <= ST_LOGS;
                ST_LOGS: begin
                    r_state <= (r_cnt == 5'(gpg_pkg::LOG_STEPS - 1)) ? ST_TLN : ST_LOGM;
                end
                ST_TLN:   r_state <= ST_LNM;
                ST_LNM:   r_state <= ST_SQW;
                ST_SQW:   r_state <= ST_WAITW;
                ST_WAITW: begin
                    if (w_sqrt.done) begin
                        r_state <= ST_SQR;
                    end
                end
                ST_SQR:   r_state <= ST_WAITR;
                ST_WAITR: begin
                    if (w_sqrt.done) begin
                        r_state <= ST_SHF;
                    end
                end
                ST_SHF:   r_state <= ST_DIV;
                ST_DIV:   r_state <= ST_WAITD;
                ST_WAITD: begin
                    if (w_div.done) begin
                        r_state <= ST_GMUL;
                    end
                end
                ST_GMUL:  r_state <= ST_GSGN;
                ST_GSGN: begin
                    r_state <= r_sel ? ST_SCLM : ST_SHF;
                    if (r_sel) begin
                        r_cache <= n_dev;
                    end
                end
                ST_SCLM:  r_state <= ST_SCLQ;
                ST_SCLQ:  r_state <= ST_SCLS;
                ST_SCLS:  r_state <= ST_EMIT;
                ST_EMIT: begin
                    if (n_load) begin
                        r_state <= ST_IDLE;
                        r_phase <= ~r_phase;
                    end
                end
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= n_mul[63:0];
        unique case (r_state)
            ST_IDLE: begin
                r_neg_a <= ~n_ua[UNIFORM_BITS-1];
                r_neg_b <= ~n_ub[UNIFORM_BITS-1];
                r_mag_a <= n_mag_a;
                r_mag_b <= n_mag_b;
                r_dev   <= r_cache;
            end
            ST_SUM: r_s <= r_s + r_prod;
            ST_SQB: r_s <= r_prod;
            ST_CHK: begin
                r_norm <= r_s;
                r_e    <= 6'd63;
            end
            // normalize one bit per cycle
            ST_NORM: begin
                if (r_norm[63]) begin
                    r_x    <= r_norm[63:32];
                    r_frac <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_norm <= {r_norm[62:0], 1'b0};
                    r_e    <= r_e - 6'd1;
                end
            end
            // log2 mantissa: one fraction bit per squaring
            ST_LOGS: begin
                r_frac <= {r_frac[30:0], r_prod[63]};
                r_x    <= r_prod[63] ? r_prod[63:32] : r_prod[62:31];
                r_cnt  <= r_cnt + 5'd1;
            end
            ST_TLN: r_t <= n_t[37:6];
            ST_WAITW: begin
                if (w_sqrt.done) begin
                    r_w <= w_sqrt.root;
                end
            end
            ST_WAITR: begin
                if (w_sqrt.done) begin
                    r_root <= w_sqrt.root;
                    r_sel  <= 1'b0;
                end
            end
            ST_SHF: r_num <= n_mag_sel << n_k;
            ST_WAITD: begin
                if (w_div.done) begin
                    r_c <= w_div.quot;
                end
            end
            ST_GSGN: begin
                if (!r_sel) begin
                    r_dev <= n_dev;
                end
                r_sel <= 1'b1;
            end
            ST_SCLQ: r_q <= 37'(n_p >>> 27);
            // add mean and saturate
            ST_SCLS: begin
                if (n_r > 38'sd2147483647) begin
                    r_res <= 32'h7FFF_FFFF;
                end else if (n_r < -38'sd2147483648) begin
                    r_res <= 32'h8000_0000;
                end else begin
                    r_res <= n_r[31:0];
                end
            end
            default: r_res <= r_res;
        endcase
    end

endmodule

>>> hw/rtl/gpg_sqrt.sv
// Bit-serial integer square root of a 64-bit radicand, two bits per cycle.
// Depends on gpg_pkg.
`timescale 1ns / 1ps

module gpg_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [gpg_pkg::WIDE_W-1:0] i_radicand,
    output gpg_pkg::t_sqrt_stat       o_stat
);

    logic [5:0]                  r_cnt;
    logic                        r_done;
    logic [gpg_pkg::WIDE_W-1:0]  r_rad;
    logic [34:0]                 r_rem;
    logic [gpg_pkg::WORD_W-1:0]  r_root;

    logic [34:0]                 n_rem_sh;
    logic [34:0]                 n_trial;
    logic                        n_ge;
    logic [34:0]                 n_rem;
    logic [gpg_pkg::WORD_W-1:0]  n_root;

    // one digit-by-digit step
    always_comb begin
        n_rem_sh = {r_rem[32:0], r_rad[63:62]};
        n_trial  = {1'b0, r_root, 2'b01};
        n_ge     = (n_rem_sh >= n_trial);
        n_rem    = n_ge ? (n_rem_sh - n_trial) : n_rem_sh;
        n_root   = {r_root[30:0], n_ge};
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= 6'(gpg_pkg::SQRT_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.root = r_root;

endmodule

>>> hw/rtl/gpg_div.sv
// Bit-serial restoring divider, numerator scaled by 2^30, one quotient bit per cycle.
// Numerator must not exceed the divisor. Depends on gpg_pkg.
`timescale 1ns / 1ps

module gpg_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [gpg_pkg::WORD_W-1:0] i_num,
    input  logic [gpg_pkg::WORD_W-1:0] i_den,
    output gpg_pkg::t_div_stat        o_stat
);

    logic [4:0]                     r_cnt;
    logic                           r_done;
    logic [32:0]                    r_rem;
    logic [gpg_pkg::WORD_W-1:0]     r_den;
    logic [gpg_pkg::DIV_STEPS-1:0]  r_quot;

    logic                           n_ge;
    logic [32:0]                    n_diff;

    // compare and subtract
    always_comb begin
        n_ge   = (r_rem >= {1'b0, r_den});
        n_diff = n_ge ? (r_rem - {1'b0, r_den}) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= 5'(gpg_pkg::DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= {n_diff[31:0], 1'b0};
            r_quot <= {r_quot[gpg_pkg::DIV_STEPS-2:0], n_ge};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_quot;

endmodule

>>> hw/rtl/gpg_checker.sv
// Port-level checker for the Gaussian polar generator, bound to the top level.
// Depends on gaussian_polar_generator_assert.svh.
`timescale 1ns / 1ps
`include "gaussian_polar_generator_assert.svh"

module gpg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    logic w_stall;
    logic w_in_txn;

    assign w_stall  = m_axis_tvalid && !m_axis_tready;
    assign w_in_txn = s_axis_tvalid && s_axis_tready;

    // a stalled sample stays offered and unchanged
    `GPG_ASSERT_NEXT(a_out_hold, w_stall, m_axis_tvalid, "output valid dropped while stalled")
    `GPG_ASSERT_NEXT(a_out_stable, w_stall, $stable(m_axis_tdata), "output data changed")

    // one item at a time: the input closes right after a transaction
    `GPG_ASSERT_NEXT(a_in_busy, w_in_txn, !s_axis_tready, "input open after a transaction")

    // reset empties the output register
    `GPG_ASSERT_NEXT_ALWAYS(a_rst_empty, !i_rst_n, !m_axis_tvalid, "output valid after reset")

endmodule

bind gaussian_polar_generator gpg_checker u_gpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/tb_gaussian_polar_generator.sv
// Self-checking testbench of the Marsaglia polar Gaussian generator.
// Depends on gpg_pkg and gaussian_polar_generator; predicts samples in integer arithmetic.
`timescale 1ns / 1ps

module tb_gaussian_polar_generator;

    localparam int N_RANDOM = 800;
    localparam int SETTLE   = 300;   // one full pair plus margin

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    gaussian_polar_generator i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // predictor state
    logic signed [31:0] mdl_mean;
    logic [31:0]        mdl_std;
    logic               mdl_phase;
    logic signed [31:0] mdl_cache;

    logic [31:0] sample_queue[$];
    int          n_fail;
    bit          quiet_out;     // no random stalls on the output
    bit          hold_out;      // long receiver hold-off
    bit          quiet_in;

    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= res + bt) begin
                x   = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic int top_bit(logic [63:0] x);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++) if (x[i]) n = i;
        return n;
    endfunction

    // signed Q4.27 deviate for offset word a
    function automatic logic signed [63:0] deviate(logic signed [63:0] a, logic [63:0] s,
                                                   logic [63:0] w);
        int          k;
        logic [63:0] root;
        logic [63:0] mag;
        logic [63:0] c;
        logic [63:0] g;
        k    = (63 - top_bit(s)) >> 1;
        root = isqrt(s << (2 * k));
        mag  = (a < 0) ? -a : a;
        c    = ((mag << k) << 30) / root;
        g    = (c * w + (64'd1 << 30)) >> 31;
        return (a < 0) ? -$signed(g) : $signed(g);
    endfunction

    function automatic logic [31:0] scale_sample(logic signed [31:0] dev);
        logic signed [127:0] p;
        logic signed [127:0] r;
        p = $signed({1'b0, mdl_std}) * dev + (128'sd1 <<< 26);
        r = (p >>> 27) + mdl_mean;
        if (r > 128'sd2147483647) r = 128'sd2147483647;
        if (r < -128'sd2147483648) r = -128'sd2147483648;
        return r[31:0];
    endfunction

    // returns 1 and the sample when the item produces one
    function automatic bit predict_sample(logic [31:0] ua, logic [31:0] ub,
                                          output logic [31:0] smp);
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [63:0]        s;
        logic [63:0]        x;
        logic [63:0]        sq;
        logic [63:0]        frac;
        logic [63:0]        t;
        logic [63:0]        y;
        logic [63:0]        w;
        logic signed [63:0] db;
        int                 e;
        smp = '0;
        if (mdl_phase) begin
            smp       = scale_sample(mdl_cache);
            mdl_phase = 1'b0;
            return 1'b1;
        end
        a = $signed({32'd0, ua}) - 64'sd2147483648;
        b = $signed({32'd0, ub}) - 64'sd2147483648;
        s = a * a + b * b;
        if (s == 0 || s >= (64'd1 << 62)) return 1'b0;
        e = top_bit(s);
        x = (e >= 31) ? (s >> (e - 31)) : (s << (31 - e));
        frac = 0;
        for (int i = 0; i < 32; i++) begin
            sq   = x * x;
            frac = frac << 1;
            if (sq[63]) begin
                frac[0] = 1'b1;
                x = sq >> 32;
            end else begin
                x = sq >> 31;
            end
        end
        t  = ((64'(62 - e)) << 32) - frac;
        y  = ((t >> 6) * 64'(gpg_pkg::LN2X2_Q30)) >> 24;
        w  = isqrt(y << 24);
        db = deviate(b, s, w);
        mdl_cache = db[31:0];
        smp       = scale_sample(32'(deviate(a, s, w)));
        mdl_phase = 1'b1;
        return 1'b1;
    endfunction

    // valid stays up after a transaction unless the next item idles first
    task automatic send_item(logic [31:0] ua, logic [31:0] ub);
        logic [31:0] smp;
        while (!quiet_in && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ub, ua};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (predict_sample(ua, ub, smp)) sample_queue.push_back(smp);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (sample_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == gpg_pkg::CFG_MEAN) mdl_mean = val;
        else mdl_std = val;
        @(posedge i_clk);
    endtask

    // receiver: random stalls, quiet stretches, one long hold-off
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_out = 1'b0;
            end
            m_axis_tready <= quiet_out || ($urandom_range(99) >= 27);
        end
    end

    // output checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (sample_queue.size() == 0) begin
                $error("unexpected sample_value %0d", $signed(m_axis_tdata));
                n_fail++;
            end else begin
                if (m_axis_tdata !== sample_queue[0]) begin
                    $error("sample_value expected %0d actual %0d",
                           $signed(sample_queue[0]), $signed(m_axis_tdata));
                    n_fail++;
                end
                void'(sample_queue.pop_front());
            end
        end
    end

    // directed rows: {uniform_a, uniform_b, known sample or none}
    typedef struct {
        logic [31:0] ua;
        logic [31:0] ub;
        bit          known;
        logic [31:0] smp;
    } t_row;

    t_row rows[$];

    initial begin
        logic [31:0] ua;
        logic [31:0] ub;
        n_fail        = 0;
        quiet_out     = 1'b0;
        hold_out      = 1'b0;
        quiet_in      = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = gpg_pkg::CFG_MEAN;
        i_cfg_data    = '0;
        mdl_mean  = 0;
        mdl_std   = 32'd65536;
        mdl_phase = 1'b0;
        mdl_cache = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pairs with S zero or at or above one (rejected unless a cached sample is due), mixed with valid pairs
        rows.push_back('{32'h8000_0000, 32'h8000_0000, 1'b0, 32'd0});
        rows.push_back('{32'h0000_0000, 32'h0000_0000, 1'b0, 32'd0});
        rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'd0});
        rows.push_back('{32'h0000_0000, 32'h8000_0000, 1'b0, 32'd0});
        rows.push_back('{32'h8000_0001, 32'h8000_0000, 1'b0, 32'd0});
        rows.push_back('{32'h8000_0000, 32'h8000_0001, 1'b0, 32'd0});
        rows.push_back('{32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'd0});
        rows.push_back('{32'h0000_0000, 32'h0000_0000, 1'b0, 32'd0});
        rows.push_back('{32'h0000_0001, 32'h8000_0000, 1'b0, 32'd0});
        rows.push_back('{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'd0});
        rows.push_back('{32'hA000_0000, 32'h6000_0000, 1'b0, 32'd0});
        rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'd0});
        rows.push_back('{32'h0000_0000, 32'h0000_0000, 1'b0, 32'd0});
        // zero first offset word: first deviate is exactly zero, sample equals the mean
        rows.push_back('{32'h8000_0000, 32'h4000_0000, 1'b1, 32'd0});
        rows.push_back('{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 32'd0});
        foreach (rows[i]) begin
            send_item(rows[i].ua, rows[i].ub);
            // rows with a typed-in sample are checked against that value
            if (rows[i].known && sample_queue.size() != 0) sample_queue[$] = rows[i].smp;
        end
        drain();

        // extreme settings: saturation on both sides, then a zero standard deviation
        write_reg(gpg_pkg::CFG_STD, 32'hFFFF_FFFF);
        write_reg(gpg_pkg::CFG_MEAN, 32'h7FFF_FFFF);
        send_item(32'h8000_0001, 32'h8000_0000);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        write_reg(gpg_pkg::CFG_MEAN, 32'h8000_0000);
        send_item(32'h7FFF_FFFF, 32'h8000_0000);
        send_item(32'h0, 32'h0);
        drain();
        write_reg(gpg_pkg::CFG_STD, 32'h0);
        send_item(32'h9000_0000, 32'h7000_0000);
        send_item(32'h1234_5678, 32'h9ABC_DEF0);
        drain();

        // random phases with a new setting each
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(gpg_pkg::CFG_MEAN, 32'd0);
                    write_reg(gpg_pkg::CFG_STD, 32'd65536);
                end
                4: begin
                    write_reg(gpg_pkg::CFG_MEAN, 32'hFFF0_0000);
                    write_reg(gpg_pkg::CFG_STD, 32'd0);
                end
                default: begin
                    write_reg(gpg_pkg::CFG_MEAN, $urandom());
                    write_reg(gpg_pkg::CFG_STD, $urandom_range(32'h00FF_FFFF));
                end
            endcase
            quiet_out = (ph == 2);
            quiet_in  = (ph == 2);
            if (ph == 1) hold_out = 1'b1;
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                ua = $urandom();
                ub = $urandom();
                if ($urandom_range(9) < 8) begin
                    // keep the pair mostly inside the unit circle
                    ua = {ua[31], {2{ua[31]}} ^ 2'b11 ^ {2{ua[31]}} & 2'b00, ua[28:0]} ^ 32'h0;
                    ua[30] = ~ua[31];
                    ub[30] = ~ub[31];
                    if ($urandom_range(3) == 0) ua[29] = ~ua[31];
                end
                send_item(ua, ub);
            end
            drain();
        end

        if (n_fail == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
